>>> rtl/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INNER     = 3'd6;

    typedef struct packed {
        logic        [15:0] sample_period;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_d;
        logic signed [31:0] gain_i;
        logic        [14:0] deadzone;
        logic        [30:0] limit;
        logic        [7:0]  min_inner;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sample_period: 16'd10,
        gain_p:        16'sd4096,
        gain_d:        16'sd0,
        gain_i:        32'sd0,
        deadzone:      15'd0,
        limit:         31'd16384000,
        min_inner:     8'd0
    };

    // 1.0 in q2.14
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // microcode
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH     = 4'd0;
    localparam step_t STEP_CHECK     = 4'd1;
    localparam step_t STEP_INT_SUM   = 4'd2;
    localparam step_t STEP_INT_CLAMP = 4'd3;
    localparam step_t STEP_PD_SUM    = 4'd4;
    localparam step_t STEP_PID_SUM   = 4'd5;
    localparam step_t STEP_CORR      = 4'd6;
    localparam step_t STEP_SCALE     = 4'd7;
    localparam step_t STEP_OUTPUT    = 4'd8;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_E_DT,
        MUL_P_E,
        MUL_D_D,
        MUL_I_INT,
        MUL_BASE_N
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_INT_SUM,
        ACC_LOAD,
        ACC_ADD,
        ACC_SHIFT_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_REJECT,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        logic     fetch;
        logic     commit;
        logic     int_wr;
        logic     corr_wr;
        logic     out_wr;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        jmp_t     jmp;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic reject;
        logic out_busy;
    } stat_t;

    // control store
    function automatic ctrl_t pds_rom(step_t s);
        ctrl_t c;
        c = '0;
        c.mul_sel = MUL_NONE;
        c.acc_op  = ACC_HOLD;
        c.jmp     = JMP_NEXT;
        c.target  = STEP_FETCH;
        unique case (s)
            STEP_FETCH:
            begin
                c.fetch = 1'b1;
                c.jmp   = JMP_WAIT_IN;
            end
            STEP_CHECK:
            begin
                c.commit  = 1'b1;
                c.mul_sel = MUL_E_DT;
                c.jmp     = JMP_REJECT;
            end
            STEP_INT_SUM:
            begin
                c.acc_op  = ACC_INT_SUM;
                c.mul_sel = MUL_P_E;
            end
            STEP_INT_CLAMP:
            begin
                c.int_wr  = 1'b1;
                c.acc_op  = ACC_LOAD;
                c.mul_sel = MUL_D_D;
            end
            STEP_PD_SUM:
            begin
                c.acc_op  = ACC_ADD;
                c.mul_sel = MUL_I_INT;
            end
            STEP_PID_SUM:
            begin
                c.acc_op = ACC_SHIFT_ADD;
            end
            STEP_CORR:
            begin
                c.corr_wr = 1'b1;
            end
            STEP_SCALE:
            begin
                c.mul_sel = MUL_BASE_N;
            end
            STEP_OUTPUT:
            begin
                c.out_wr = 1'b1;
                c.jmp    = JMP_WAIT_OUT;
            end
            default:
            begin
                c.jmp = JMP_WAIT_OUT;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pds_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pds_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [31:0]        time_ms;
    logic signed [15:0] line_position;
    logic [7:0]         base_speed;

    modport source (output valid, action, time_ms, line_position, base_speed, input ready);
    modport sink   (input valid, action, time_ms, line_position, base_speed, output ready);
endinterface

`default_nettype wire

>>> rtl/pds_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pds_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         left_speed;
    logic [7:0]         right_speed;
    logic signed [15:0] correction;

    modport source (output valid, left_speed, right_speed, correction, input ready);
    modport sink   (input valid, left_speed, right_speed, correction, output ready);
endinterface

`default_nettype wire

>>> rtl/pds_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_data,
    output pds_pkg::cfg_t                  cfg
);
    import pds_pkg::*;

    cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg_data[15:0];
                CFG_GAIN_P:        cfg_reg.gain_p        <= cfg_data[15:0];
                CFG_GAIN_D:        cfg_reg.gain_d        <= cfg_data[15:0];
                CFG_GAIN_I:        cfg_reg.gain_i        <= cfg_data[31:0];
                CFG_DEADZONE:      cfg_reg.deadzone      <= cfg_data[14:0];
                CFG_LIMIT:         cfg_reg.limit         <= cfg_data[30:0];
                CFG_MIN_INNER:     cfg_reg.min_inner     <= cfg_data[7:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/pds_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  pds_pkg::stat_t stat,
    output pds_pkg::ctrl_t ctrl
);
    import pds_pkg::*;

    step_t step_reg;
    step_t step_next;

    // control word lookup
    always_comb
    begin
        ctrl = pds_rom(step_reg);
    end

    // next step and conditional jumps
    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.jmp)
            JMP_NEXT:     step_next = step_reg + step_t'(1);
            JMP_WAIT_IN:  step_next = stat.in_valid ? step_reg + step_t'(1) : step_reg;
            JMP_REJECT:   step_next = stat.reject ? ctrl.target : step_reg + step_t'(1);
            JMP_WAIT_OUT: step_next = stat.out_busy ? step_reg : ctrl.target;
            default:      step_next = STEP_FETCH;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  pds_pkg::ctrl_t ctrl,
    input  pds_pkg::cfg_t  cfg,
    output pds_pkg::stat_t stat,
    pds_in_if.sink         samples,
    pds_out_if.source      results
);
    import pds_pkg::*;

    logic               fire;
    logic               action_reg;
    logic [31:0]        time_reg;
    logic [31:0]        dt_reg;
    logic signed [15:0] err_reg;
    logic [7:0]         base_reg;

    logic [31:0]        last_time_reg;
    logic signed [15:0] prev_err_reg;
    logic signed [16:0] diff_reg;
    logic signed [31:0] integral_reg;
    logic signed [31:0] integral_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [63:0] int_ext;

    logic [16:0]        err_ext;
    logic [16:0]        err_mag;
    logic signed [63:0] lim_pos;
    logic signed [63:0] lim_neg;

    logic signed [63:0] corr_shift;
    logic signed [15:0] corr_reg;
    logic signed [15:0] corr_next;
    logic [16:0]        corr_ext;
    logic [16:0]        corr_mag;
    logic [14:0]        n_clip;
    logic [14:0]        scale_factor;

    logic [7:0]         x_speed;
    logic [7:0]         inner;
    logic               reject;
    logic               out_busy;
    logic               out_load;
    logic               out_valid_reg;
    logic [7:0]         left_reg;
    logic [7:0]         right_reg;
    logic signed [15:0] corr_out_reg;

    // input transaction
    assign samples.ready = ctrl.fetch;
    assign fire          = ctrl.fetch && samples.valid;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            action_reg <= samples.action;
            time_reg   <= samples.time_ms;
            err_reg    <= samples.line_position;
            base_reg   <= samples.base_speed;
            dt_reg     <= samples.time_ms - last_time_reg;
        end
    end

    // early sample or reset action ends the program
    assign reject = action_reg || (dt_reg < {16'd0, cfg.sample_period});

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            prev_err_reg  <= '0;
            integral_reg  <= '0;
        end
        else
        begin
            if (ctrl.commit && action_reg)
            begin
                last_time_reg <= '0;
                prev_err_reg  <= '0;
                integral_reg  <= '0;
            end
            else
            begin
                if (ctrl.commit && !reject)
                begin
                    last_time_reg <= time_reg;
                    prev_err_reg  <= err_reg;
                end
                if (ctrl.int_wr)
                begin
                    integral_reg <= integral_next;
                end
            end
        end
    end

    // error difference
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            diff_reg <= $signed({err_reg[15], err_reg}) - $signed({prev_err_reg[15], prev_err_reg});
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_E_DT:
            begin
                mul_a = {{17{err_reg[15]}}, err_reg};
                mul_b = {1'b0, dt_reg};
            end
            MUL_P_E:
            begin
                mul_a = {{17{cfg.gain_p[15]}}, cfg.gain_p};
                mul_b = {{17{err_reg[15]}}, err_reg};
            end
            MUL_D_D:
            begin
                mul_a = {{17{cfg.gain_d[15]}}, cfg.gain_d};
                mul_b = {{16{diff_reg[16]}}, diff_reg};
            end
            MUL_I_INT:
            begin
                mul_a = {cfg.gain_i[31], cfg.gain_i};
                mul_b = {integral_reg[31], integral_reg};
            end
            MUL_BASE_N:
            begin
                mul_a = {25'd0, base_reg};
                mul_b = {18'd0, scale_factor};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_p[63:0];
        end
    end

    // accumulator
    assign int_ext = {{32{integral_reg[31]}}, integral_reg};

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_INT_SUM:   acc_next = int_ext + prod_reg;
            ACC_LOAD:      acc_next = prod_reg;
            ACC_ADD:       acc_next = acc_reg + prod_reg;
            ACC_SHIFT_ADD: acc_next = (acc_reg <<< 12) + prod_reg;
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // integral clamp and deadzone
    assign err_ext = {err_reg[15], err_reg};
    assign err_mag = err_reg[15] ? (~err_ext + 17'd1) : err_ext;
    assign lim_pos = $signed({33'd0, cfg.limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (err_mag <= {2'd0, cfg.deadzone})
        begin
            integral_next = '0;
        end
        else if (acc_reg > lim_pos)
        begin
            integral_next = lim_pos[31:0];
        end
        else if (acc_reg < lim_neg)
        begin
            integral_next = lim_neg[31:0];
        end
        else
        begin
            integral_next = acc_reg[31:0];
        end
    end

    // correction, floor shift and saturate to q2.14
    assign corr_shift = acc_reg >>> 24;

    always_comb
    begin
        if (corr_shift > 64'sd32767)
        begin
            corr_next = 16'sh7FFF;
        end
        else if (corr_shift < -64'sd32768)
        begin
            corr_next = 16'sh8000;
        end
        else
        begin
            corr_next = corr_shift[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.corr_wr)
        begin
            corr_reg <= corr_next;
        end
    end

    // inner wheel scale factor
    assign corr_ext     = {corr_reg[15], corr_reg};
    assign corr_mag     = corr_reg[15] ? (~corr_ext + 17'd1) : corr_ext;
    assign n_clip       = (corr_mag > {2'd0, ONE_Q14}) ? ONE_Q14 : corr_mag[14:0];
    assign scale_factor = ONE_Q14 - n_clip;

    // inner wheel speed
    assign x_speed = prod_reg[21:14];

    always_comb
    begin
        if (x_speed < cfg.min_inner)
        begin
            inner = cfg.min_inner;
        end
        else if (x_speed > base_reg)
        begin
            inner = base_reg;
        end
        else
        begin
            inner = x_speed;
        end
    end

    // output register
    assign out_busy = out_valid_reg && !results.ready;
    assign out_load = ctrl.out_wr && !out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_reg     <= corr_reg[15] ? inner : base_reg;
            right_reg    <= corr_reg[15] ? base_reg : inner;
            corr_out_reg <= corr_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.left_speed  = left_reg;
    assign results.right_speed = right_reg;
    assign results.correction  = corr_out_reg;

    // status to sequencer
    assign stat.in_valid = samples.valid;
    assign stat.reject   = reject;
    assign stat.out_busy = out_busy;

endmodule

`default_nettype wire

>>> rtl/pid_differential_steering_top.sv
// pid differential steering controller
//
// samples channel (valid/ready): action, time_ms, line_position, base_speed.
// results channel (valid/ready): left_speed, right_speed, correction.
// cfg port: cfg_we, cfg_index, cfg_data; write only while no sample is in work.
//
// a short program in a control store steps one shared 33x33 multiplier and a
// 64-bit accumulator through the pid terms, at most one multiply per step. a
// control sample runs fetch, check, int_sum, int_clamp, pd_sum, pid_sum, corr,
// scale and output, where its result is registered; the next sample is only
// accepted once the program is back in fetch. an early sample or a reset
// action goes from check straight back to fetch and gives no result.
//
// reset clears the controller state and the output valid flag, and sets the
// config registers to their defaults. a stalled receiver holds the result in
// the output register; the next sample is still accepted and computed, and it
// waits in its last step until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module pid_differential_steering_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_data,
    pds_in_if.sink                         samples,
    pds_out_if.source                      results
);
    import pds_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;

    // configuration registers
    pds_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // step counter and control store
    pds_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // arithmetic and state
    pds_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cfg     (cfg),
        .stat    (stat),
        .samples (samples),
        .results (results)
    );

    // one sample in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("sample accepted while another is in work");

    // rejected samples return straight to fetch
    a_reject_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.jmp == JMP_REJECT && stat.reject |=> samples.ready)
        else $error("rejected sample did not return to fetch");

    // results only come from the output step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(ctrl.out_wr))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire
